[rtl/core/ddo_pkg.sv]
// Shared types, constants and command word for the wheel odometry block.
package ddo_pkg;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int ITER_W       = 5;
  localparam int CORDIC_STEPS = 24;
  localparam int MOD_CYCLES   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DPT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IWB  = 2'd2;

  localparam logic [31:0] DPT_RESET  = 32'd1349304;
  localparam logic [13:0] RATE_RESET = 14'd50;
  localparam logic [23:0] IWB_RESET  = 24'd218453;

  localparam longint PI_Q          = 64'd1686629713;
  localparam longint HALF_PI_Q     = 64'd843314857;
  localparam longint TWO_PI_Q      = 64'd3373259426;
  localparam longint TWO32_MOD_2PI = 64'd921707870;
  localparam longint CORDIC_GAIN   = 64'd652032874;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_speed;
    logic signed [31:0] yaw_rate;
  } out_word_t;

  typedef enum logic [3:0] {
    MUL_HALF, MUL_P, MUL_V0, MUL_V1, MUL_LO, MUL_HI, MUL_Y0, MUL_Y1,
    MUL_Q, MUL_CL, MUL_CH, MUL_SL, MUL_SH
  } mul_op_t;

  typedef struct packed {
    mul_op_t           mul_op;
    logic              ld_in;
    logic              st_half;
    logic              st_p;
    logic              st_vlo;
    logic              st_lin;
    logic              st_lo;
    logic              st_hi2;
    logic              st_ylo;
    logic              st_yaw;
    logic              mod_ld1;
    logic              mod_ld2;
    logic              mod_step;
    logic              head;
    logic              cor_step;
    logic [ITER_W-1:0] iter;
    logic              st_plo;
    logic              st_t;
    logic              upd_x;
    logic              upd_y;
    logic              out_ld;
  } cmd_t;

  function automatic logic [31:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/ddo_ctrl.sv]
// Sequencer that steps the odometry datapath through one word.
module ddo_ctrl
  import ddo_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_HALF   = 23'h000002,
    S_P      = 23'h000004,
    S_V0     = 23'h000008,
    S_V1     = 23'h000010,
    S_LO     = 23'h000020,
    S_HI     = 23'h000040,
    S_Y0     = 23'h000080,
    S_Y1     = 23'h000100,
    S_YAW    = 23'h000200,
    S_MOD1   = 23'h000400,
    S_Q      = 23'h000800,
    S_MOD2LD = 23'h001000,
    S_MOD2   = 23'h002000,
    S_HEAD   = 23'h004000,
    S_COR    = 23'h008000,
    S_CL     = 23'h010000,
    S_CH     = 23'h020000,
    S_SL     = 23'h040000,
    S_SH     = 23'h080000,
    S_TY     = 23'h100000,
    S_UPY    = 23'h200000,
    S_OUT    = 23'h400000
  } state_t;

  localparam logic [ITER_W-1:0] MOD_LAST = ITER_W'(MOD_CYCLES - 1);
  localparam logic [ITER_W-1:0] COR_LAST = ITER_W'(CORDIC_STEPS - 1);

  state_t            state, state_next;
  logic [ITER_W-1:0] cnt, cnt_next;
  logic              out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_op = MUL_HALF;
    cmd.iter   = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = S_HALF;
        end
      end
      S_HALF: begin
        cmd.mul_op = MUL_HALF;
        state_next = S_P;
      end
      S_P: begin
        cmd.mul_op  = MUL_P;
        cmd.st_half = 1'b1;
        state_next  = S_V0;
      end
      S_V0: begin
        cmd.mul_op = MUL_V0;
        cmd.st_p   = 1'b1;
        state_next = S_V1;
      end
      S_V1: begin
        cmd.mul_op = MUL_V1;
        cmd.st_vlo = 1'b1;
        state_next = S_LO;
      end
      S_LO: begin
        cmd.mul_op = MUL_LO;
        cmd.st_lin = 1'b1;
        state_next = S_HI;
      end
      S_HI: begin
        cmd.mul_op = MUL_HI;
        cmd.st_lo  = 1'b1;
        state_next = S_Y0;
      end
      S_Y0: begin
        cmd.mul_op = MUL_Y0;
        cmd.st_hi2 = 1'b1;
        state_next = S_Y1;
      end
      S_Y1: begin
        cmd.mul_op = MUL_Y1;
        cmd.st_ylo = 1'b1;
        state_next = S_YAW;
      end
      S_YAW: begin
        cmd.st_yaw  = 1'b1;
        cmd.mod_ld1 = 1'b1;
        cnt_next    = '0;
        state_next  = S_MOD1;
      end
      S_MOD1: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MOD_LAST) begin
          state_next = S_Q;
        end
      end
      S_Q: begin
        cmd.mul_op = MUL_Q;
        state_next = S_MOD2LD;
      end
      S_MOD2LD: begin
        cmd.mod_ld2 = 1'b1;
        cnt_next    = '0;
        state_next  = S_MOD2;
      end
      S_MOD2: begin
        cmd.mod_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MOD_LAST) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head   = 1'b1;
        cnt_next   = '0;
        state_next = S_COR;
      end
      S_COR: begin
        cmd.cor_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == COR_LAST) begin
          state_next = S_CL;
        end
      end
      S_CL: begin
        cmd.mul_op = MUL_CL;
        state_next = S_CH;
      end
      S_CH: begin
        cmd.mul_op = MUL_CH;
        cmd.st_plo = 1'b1;
        state_next = S_SL;
      end
      S_SL: begin
        cmd.mul_op = MUL_SL;
        cmd.st_t   = 1'b1;
        state_next = S_SH;
      end
      S_SH: begin
        cmd.mul_op = MUL_SH;
        cmd.st_plo = 1'b1;
        cmd.upd_x  = 1'b1;
        state_next = S_TY;
      end
      S_TY: begin
        cmd.st_t   = 1'b1;
        state_next = S_UPY;
      end
      S_UPY: begin
        cmd.upd_y  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/ddo_datapath.sv]
// Odometry datapath: config registers, shared multiplier, modulo unit, CORDIC.
module ddo_datapath
  import ddo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  input  in_word_t              in_data,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [32:0]        MOD_M   = 33'(TWO_PI_Q);
  localparam logic [31:0]        MOD_K   = 32'(TWO32_MOD_2PI);
  localparam logic signed [33:0] PI_S    = 34'(PI_Q);
  localparam logic signed [33:0] TWOPI_S = 34'(TWO_PI_Q);
  localparam logic signed [33:0] HPI_S   = 34'(HALF_PI_Q);
  localparam logic signed [33:0] GAIN_S  = 34'(CORDIC_GAIN);

  function automatic logic [31:0] signed_out(input logic [63:0] mag, input logic neg);
    logic [31:0] v;
    if (neg) begin
      v = (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
    end else begin
      v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return v;
  endfunction

  function automatic logic [31:0] advance(input logic [31:0] acc, input logic [49:0] step,
                                          input logic neg);
    logic signed [51:0] a;
    logic signed [51:0] s;
    logic signed [51:0] r;
    logic [31:0]        v;
    a = 52'(signed'(acc));
    s = signed'({2'b00, step});
    r = neg ? a - s : a + s;
    if (r > 52'sh7FFF_FFFF) begin
      v = 32'h7FFF_FFFF;
    end else if (r < -52'sh8000_0000) begin
      v = 32'h8000_0000;
    end else begin
      v = r[31:0];
    end
    return v;
  endfunction

  logic [31:0] dpt;
  logic [13:0] rate;
  logic [23:0] iwb;

  logic [31:0] prev_left, prev_right;
  logic [32:0] sm, dm;
  logic        sneg, dneg;

  logic [64:0] prod;
  logic [32:0] mul_a;
  logic [31:0] mul_b;

  logic [62:0] half;
  logic [55:0] p;
  logic [45:0] vlo;
  logic [31:0] lin;
  logic [64:0] lo;
  logic [57:0] hi2;
  logic [45:0] ylo;
  logic [31:0] yaw;

  logic [63:0] mv;
  logic [31:0] rem;

  logic [31:0]        acc_heading, acc_x, acc_y;
  logic               flip;
  logic signed [33:0] cx, cy, cz;
  logic [63:0]        plo;
  logic [63:0]        t;

  logic signed [32:0] dl, dr, sum, diff;
  logic [31:0]        dl32, dr32;
  logic [31:0]        ax, ay;
  logic               fneg_x, fneg_y;
  logic [31:0]        ql;
  logic [32:0]        r1, r1m, r2, r2m;
  logic signed [33:0] ah, rext, hs, hw, hh;
  logic signed [33:0] sx, sy, atn;
  logic [61:0]        vm;
  logic [63:0]        ym;

  always_comb begin
    dl32 = in_data.left_count - prev_left;
    dr32 = in_data.right_count - prev_right;
    dl   = 33'(signed'(dl32));
    dr   = 33'(signed'(dr32));
    sum  = dl + dr;
    diff = dr - dl;
  end

  always_comb begin
    ax     = cx[33] ? 32'(-cx) : cx[31:0];
    ay     = cy[33] ? 32'(-cy) : cy[31:0];
    fneg_x = flip ? (cx > 34'sd0) : cx[33];
    fneg_y = flip ? (cy > 34'sd0) : cy[33];
    ql     = {hi2[18:0], lo[31:19]};
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_HALF: begin mul_a = sm;                  mul_b = dpt; end
      MUL_P:    begin mul_a = {1'b0, dpt};         mul_b = {8'd0, iwb}; end
      MUL_V0:   begin mul_a = {1'b0, half[31:0]};  mul_b = 32'(rate); end
      MUL_V1:   begin mul_a = 33'(half[62:32]);    mul_b = 32'(rate); end
      MUL_LO:   begin mul_a = dm;                  mul_b = p[31:0]; end
      MUL_HI:   begin mul_a = dm;                  mul_b = {8'd0, p[55:32]}; end
      MUL_Y0:   begin mul_a = {1'b0, lo[31:0]};    mul_b = 32'(rate); end
      MUL_Y1:   begin mul_a = 33'(hi2[30:0]);      mul_b = 32'(rate); end
      MUL_Q:    begin mul_a = {1'b0, rem};         mul_b = MOD_K; end
      MUL_CL:   begin mul_a = {1'b0, half[31:0]};  mul_b = ax; end
      MUL_CH:   begin mul_a = 33'(half[62:32]);    mul_b = ax; end
      MUL_SL:   begin mul_a = {1'b0, half[31:0]};  mul_b = ay; end
      MUL_SH:   begin mul_a = 33'(half[62:32]);    mul_b = ay; end
      default:  begin mul_a = '0;                  mul_b = '0; end
    endcase
  end

  always_comb begin
    r1  = {rem, mv[63]};
    r1m = (r1 >= MOD_M) ? r1 - MOD_M : r1;
    r2  = {r1m[31:0], mv[62]};
    r2m = (r2 >= MOD_M) ? r2 - MOD_M : r2;
  end

  always_comb begin
    ah   = 34'(signed'(acc_heading));
    rext = signed'({2'b00, rem});
    hs   = dneg ? ah - rext : ah + rext;
    if (hs > PI_S) begin
      hw = hs - TWOPI_S;
    end else if (hs < -PI_S) begin
      hw = hs + TWOPI_S;
    end else begin
      hw = hs;
    end
    if (hw > HPI_S) begin
      hh = hw - PI_S;
    end else if (hw < -HPI_S) begin
      hh = hw + PI_S;
    end else begin
      hh = hw;
    end
  end

  always_comb begin
    sx  = cx >>> cmd.iter;
    sy  = cy >>> cmd.iter;
    atn = signed'({2'b00, atan_entry(cmd.iter)});
  end

  always_comb begin
    vm = {prod[44:0], 16'd0} + 62'(vlo[45:16]);
    if (rate == '0) begin
      ym = '0;
    end else if (hi2[57:31] != '0) begin
      ym = 64'h1_0000_0000;
    end else begin
      ym = 64'(prod[44:0]) + 64'(ylo[45:32]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dpt         <= DPT_RESET;
      rate        <= RATE_RESET;
      iwb         <= IWB_RESET;
      prev_left   <= '0;
      prev_right  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_DPT:  dpt  <= cfg_data;
          REG_RATE: rate <= cfg_data[13:0];
          REG_IWB:  iwb  <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (cmd.ld_in) begin
        prev_left  <= in_data.left_count;
        prev_right <= in_data.right_count;
      end
      if (cmd.head) begin
        acc_heading <= hw[31:0];
      end
      if (cmd.upd_x) begin
        acc_x <= advance(acc_x, t[63:14], sneg ^ fneg_x);
      end
      if (cmd.upd_y) begin
        acc_y <= advance(acc_y, t[63:14], sneg ^ fneg_y);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.ld_in) begin
      sneg <= sum[32];
      dneg <= diff[32];
      sm   <= sum[32] ? 33'(-sum) : sum;
      dm   <= diff[32] ? 33'(-diff) : diff;
    end
    if (cmd.st_half) half <= prod[63:1];
    if (cmd.st_p)    p    <= prod[55:0];
    if (cmd.st_vlo)  vlo  <= prod[45:0];
    if (cmd.st_lin)  lin  <= signed_out(64'(vm), sneg);
    if (cmd.st_lo)   lo   <= prod;
    if (cmd.st_hi2)  hi2  <= 58'(prod[56:0]) + 58'(lo[64:32]);
    if (cmd.st_ylo)  ylo  <= prod[45:0];
    if (cmd.st_yaw)  yaw  <= signed_out(ym, dneg);
    if (cmd.mod_ld1) begin
      mv  <= 64'(hi2[57:19]);
      rem <= '0;
    end else if (cmd.mod_ld2) begin
      mv  <= prod[63:0] + 64'(ql);
      rem <= '0;
    end else if (cmd.mod_step) begin
      mv  <= {mv[61:0], 2'b00};
      rem <= r2m[31:0];
    end
    if (cmd.head) begin
      flip <= (hw != hh);
      cz   <= hh <<< 1;
      cx   <= GAIN_S;
      cy   <= '0;
    end else if (cmd.cor_step) begin
      if (!cz[33]) begin
        cx <= cx - sy;
        cy <= cy + sx;
        cz <= cz - atn;
      end else begin
        cx <= cx + sy;
        cy <= cy - sx;
        cz <= cz + atn;
      end
    end
    if (cmd.st_plo) plo <= prod[63:0];
    if (cmd.st_t)   t   <= prod[63:0] + 64'(plo[63:32]);
    if (cmd.out_ld) begin
      out_data.pos_x     <= acc_x;
      out_data.pos_y     <= acc_y;
      out_data.heading   <= acc_heading;
      out_data.lin_speed <= lin;
      out_data.yaw_rate  <= yaw;
    end
  end

endmodule

[rtl/core/diff_drive_odometry.sv]
// Top level of the differential drive wheel odometry block.
// One word at a time: the two serial modulo-2pi reductions and the 24-step
// CORDIC run in turn for each word; a new input word is taken while a result
// word still waits.
// Reset (synchronous, active high) clears counts, pose and heading and loads
// the register defaults.
module diff_drive_odometry
  import ddo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ddo_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

endmodule
